// ===== src/ils_pkg.sv =====
// Shared definitions for the indexed list store: field widths, command codes
// and default sizes. No dependencies.
`default_nettype none
package ils_pkg;

	// Field widths of the command and result transactions
	localparam int CMD_W    = 3;
	localparam int INDEX_W  = 10;
	localparam int VALUE_W  = 32;
	localparam int LENGTH_W = 11;

	// Default list sizes
	localparam int DEF_CAPACITY   = 1024;
	localparam int DEF_DATA_WIDTH = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

endpackage
`default_nettype wire

// ===== src/indexed_list_store.sv =====
// Top level of the indexed list store: command sequencer, shared pointer
// incrementer, element count and result register. Uses ils_pkg and ils_ram.
`default_nettype none
// A bounded ordered list of CAPACITY words of DATA_WIDTH bits held in one
// simple dual-port RAM. One command transaction is taken at a time; in_ready
// is high only while the sequencer is idle. Push, write, clear and every error
// go from decode straight to the final state; pop and read pass through a wait
// state for the registered RAM read; delete at index i with elements behind it
// walks the RAM with the shared incrementer, moving one element a cycle through
// its read and write ports. A result may wait in the output register while the
// next command is accepted; the sequencer holds in its final state until that
// register is free. The store needs no clearing after reset: only entries below
// the length are ever returned or moved.
module indexed_list_store #(
	parameter int CAPACITY   = ils_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = ils_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ils_pkg::CMD_W-1:0]    cmd,
	input  wire logic [ils_pkg::INDEX_W-1:0]  index,
	input  wire logic [ils_pkg::VALUE_W-1:0]  value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [ils_pkg::VALUE_W-1:0]  read_value,
	output logic      [ils_pkg::LENGTH_W-1:0] length,
	output logic                              error
);
	import ils_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_RDWAIT = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;

	logic [CMD_W-1:0]    cmd_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [VALUE_W-1:0]  val_q;
	logic [CW-1:0]       wr_ptr_q;
	logic [CW-1:0]       rd_ptr_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic                res_err_q;
	logic [VALUE_W-1:0]  read_value_q;
	logic [LENGTH_W-1:0] length_q;
	logic                error_q;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [DATA_WIDTH-1:0]  mem_wdata;
	logic [AW-1:0]          mem_raddr;
	logic [DATA_WIDTH-1:0]  mem_rdata;

	logic [CW-1:0]          inc_a;
	logic [CW-1:0]          inc_y;
	logic [CW-1:0]          cnt_dec;
	logic                   full;
	logic                   empty;
	logic                   in_range;
	logic [63:0]            val_ext;
	logic [63:0]            rd_ext;
	logic [DATA_WIDTH-1:0]  val_w;
	logic                   in_fire;
	logic                   res_load;

	ils_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Status of the list and width adaption of the data words
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign cnt_dec  = count_q - CW'(1);
	assign in_range = (CMPW'(idx_q) < CMPW'(count_q));
	assign val_ext  = 64'(val_q);
	assign val_w    = val_ext[DATA_WIDTH-1:0];
	assign rd_ext   = 64'(mem_rdata);

	// Handshake
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign read_value = read_value_q;
	assign length     = length_q;
	assign error      = error_q;

	// Shared incrementer: index on decode, read pointer while shifting
	always_comb begin
		inc_a = rd_ptr_q;
		if (state_q == ST_DECODE) begin
			inc_a = CW'(idx_q);
		end
		inc_y = inc_a + CW'(1);
	end

	// Drive the RAM ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(wr_ptr_q);
		mem_wdata = mem_rdata;
		mem_raddr = AW'(inc_y);
		case (state_q)
			ST_DECODE: begin
				case (cmd_q)
					CMD_PUSH: begin
						mem_we    = !full;
						mem_waddr = AW'(count_q);
						mem_wdata = val_w;
					end
					CMD_POP: begin
						mem_raddr = AW'(cnt_dec);
					end
					CMD_READ: begin
						mem_raddr = AW'(idx_q);
					end
					CMD_WRITE: begin
						mem_we    = in_range;
						mem_waddr = AW'(idx_q);
						mem_wdata = val_w;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer, element count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (cmd_q)
						CMD_PUSH: begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= ST_DONE;
						end
						CMD_POP: begin
							if (!empty) begin
								count_q <= cnt_dec;
								state_q <= ST_RDWAIT;
							end else begin
								state_q <= ST_DONE;
							end
						end
						CMD_READ: begin
							if (in_range) begin
								state_q <= ST_RDWAIT;
							end else begin
								state_q <= ST_DONE;
							end
						end
						CMD_DELETE: begin
							if (in_range && (inc_y < count_q)) begin
								state_q <= ST_SHIFT;
							end else begin
								if (in_range) begin
									count_q <= cnt_dec;
								end
								state_q <= ST_DONE;
							end
						end
						CMD_CLEAR: begin
							count_q <= '0;
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_SHIFT: begin
					if (inc_y == count_q) begin
						count_q <= cnt_dec;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the command, walk the pointers and build the result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd;
			idx_q <= index;
			val_q <= value;
		end
		case (state_q)
			ST_DECODE: begin
				res_value_q <= '0;
				wr_ptr_q    <= CW'(idx_q);
				rd_ptr_q    <= inc_y;
				case (cmd_q)
					CMD_PUSH:   res_err_q <= full;
					CMD_POP:    res_err_q <= empty;
					CMD_READ:   res_err_q <= !in_range;
					CMD_WRITE:  res_err_q <= !in_range;
					CMD_DELETE: res_err_q <= !in_range;
					CMD_CLEAR:  res_err_q <= 1'b0;
					default:    res_err_q <= 1'b1;
				endcase
			end
			ST_RDWAIT: begin
				res_value_q <= rd_ext[VALUE_W-1:0];
			end
			ST_SHIFT: begin
				wr_ptr_q <= rd_ptr_q;
				rd_ptr_q <= inc_y;
			end
			default: begin
				res_err_q <= res_err_q;
			end
		endcase
		if (res_load) begin
			read_value_q <= res_value_q;
			length_q     <= LENGTH_W'(count_q);
			error_q      <= res_err_q;
		end
	end

	// Checks on the sequencer
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_shift_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (rd_ptr_q == wr_ptr_q + CW'(1)) && (rd_ptr_q < count_q))
		else $error("shift pointers out of step");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

endmodule
`default_nettype wire

// ===== src/ils_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
